### hw/rtl/gost_block_cipher_core_macros.svh
// assertion macros for the gost block cipher core
// expects clk and rst_n in the scope of each use
`ifndef GOST_BLOCK_CIPHER_CORE_MACROS_SVH
`define GOST_BLOCK_CIPHER_CORE_MACROS_SVH

// antecedent implies consequent after a fixed number of cycles
`define GBC_ASSERT_DELAY(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define GBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// antecedent implies consequent in the same cycle
`define GBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hw/rtl/gbc_pkg.sv
// shared types, constants and s-box rom for the gost block cipher core
// no dependencies
`default_nettype none

package gbc_pkg;

  localparam int KEY_WORDS      = 8;
  localparam int KEY_IDX_W      = 3;
  localparam int CFG_IDX_W      = 4;
  localparam int NUM_ROUNDS     = 32;
  localparam int ENC_FWD_ROUNDS = 24;
  localparam int MAC_ROUNDS     = 16;
  localparam int ROT_LEFT       = 11;
  // input register, round stages, output register
  localparam int LATENCY        = NUM_ROUNDS + 2;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_MAC     = 1'b1;

  localparam logic [31:0] SBOX_ROM [16] = '{
    32'hc983edc4, 32'h6bfe9892, 32'h5c65beff, 32'h20b92ce5,
    32'hb3165789, 32'h0698f311, 32'h97c07930, 32'hd55d1aa8,
    32'h34da012e, 32'he83bd573, 32'h7e77c24b, 32'hafac64dc,
    32'hf102a66d, 32'h4ae14f07, 32'h122f30ba, 32'h8d448b56
  };

  typedef struct packed {
    logic        operation;
    logic [31:0] half_a_in;
    logic [31:0] half_b_in;
  } in_t;

  typedef struct packed {
    logic [31:0] half_a_out;
    logic [31:0] half_b_out;
  } out_t;

  // p is the half updated on even rounds, q on odd rounds
  typedef struct packed {
    logic        valid;
    logic        op;
    logic [31:0] p;
    logic [31:0] q;
  } stage_t;

  // nibble n of the result is nibble n of the rom word chosen by nibble n of t
  function automatic logic [31:0] sbox_subst(input logic [31:0] t);
    logic [31:0] s;
    logic [31:0] w;
    s = '0;
    for (int n = 0; n < 8; n++) begin
      w = SBOX_ROM[t[4*n +: 4]];
      s[4*n +: 4] = w[4*n +: 4];
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/gbc_round.sv
// one registered round stage of the gost block cipher core
// depends on gbc_pkg
`default_nettype none

module gbc_round (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [31:0]    round_key,
  input  wire logic           upd_q,     // 0: update p from q, 1: update q from p
  input  wire logic           mac_skip,  // stage lies past the end of a mac step
  input  wire gbc_pkg::stage_t stg_i,
  output gbc_pkg::stage_t      stg_o
);
  import gbc_pkg::*;

  stage_t      stg_r;
  stage_t      stg_nxt;
  logic [31:0] x;
  logic [31:0] y;
  logic [31:0] sum;
  logic [31:0] sub;
  logic [31:0] rot;
  logic [31:0] x_new;

  always_comb begin
    x     = upd_q ? stg_i.q : stg_i.p;
    y     = upd_q ? stg_i.p : stg_i.q;
    sum   = y + round_key;
    sub   = sbox_subst(sum);
    rot   = {sub[31-ROT_LEFT:0], sub[31:32-ROT_LEFT]};
    x_new = x ^ rot;

    stg_nxt = stg_i;
    if (!(mac_skip && (stg_i.op == OP_MAC))) begin
      if (upd_q) begin
        stg_nxt.q = x_new;
      end else begin
        stg_nxt.p = x_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.valid <= 1'b0;
    end else begin
      stg_r.valid <= stg_nxt.valid;
    end
    stg_r.op <= stg_nxt.op;
    stg_r.p  <= stg_nxt.p;
    stg_r.q  <= stg_nxt.q;
  end

  assign stg_o = stg_r;

endmodule

`default_nettype wire

### hw/rtl/gost_block_cipher_core.sv
// top level of the gost 28147-89 style block cipher core, one lane
// depends on gbc_pkg, gbc_round and gost_block_cipher_core_macros.svh
//
// channel   ports                               direction  notes
// input     start, busy, in_data                in         taken when start && !busy
// result    out_strobe, out_data                out        one cycle, cannot be held off
// config    cfg_we, cfg_index, cfg_wdata        in         key words 0..7, no read-back
//
// a fully unrolled pipeline: input register, 32 round stages, output register
// one transaction may enter every cycle while busy is low
// each of the 32 round stages does one round (add, s-box, rotate, xor)
// a mac step runs the same depth, its last 16 stages pass the halves through
// busy is high only while reset is held; reset clears valid bits and key words
// nothing stalls: the receiver cannot hold results off
`default_nettype none

module gost_block_cipher_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire gbc_pkg::in_t                  in_data,
  output logic                               out_strobe,
  output gbc_pkg::out_t                      out_data,
  input  wire logic                          cfg_we,
  input  wire logic [gbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_wdata
);
  import gbc_pkg::*;

  `include "gost_block_cipher_core_macros.svh"

  // key words
  logic [KEY_WORDS-1:0][31:0] key_r;

  // pipeline stages: index 0 is the input register
  stage_t stg [NUM_ROUNDS+1];
  stage_t in_stg_r;

  logic   accept;
  logic   cfg_stray;
  logic   out_strobe_r;
  out_t   out_data_r;
  out_t   out_data_nxt;

  assign busy   = !rst_n;
  assign accept = start && !busy;

  // write to an index past the last key word
  assign cfg_stray = cfg_we && (cfg_index >= CFG_IDX_W'(KEY_WORDS));

  // config writes, indexes past the last key word are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we && !cfg_stray) begin
      key_r[cfg_index[KEY_IDX_W-1:0]] <= cfg_wdata;
    end
  end

  // both operations start with p = b and q = a:
  // encrypt swaps then updates a first, mac updates b first without a swap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_stg_r.valid <= 1'b0;
    end else begin
      in_stg_r.valid <= accept;
    end
    in_stg_r.op <= in_data.operation;
    in_stg_r.p  <= in_data.half_b_in;
    in_stg_r.q  <= in_data.half_a_in;
  end

  assign stg[0] = in_stg_r;

  // round stages with a fixed key word each
  for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
    // key order 0..7 for the first 24 rounds, then 7..0
    localparam int KIDX = (g < ENC_FWD_ROUNDS) ? (g % KEY_WORDS)
                                               : (KEY_WORDS - 1 - (g % KEY_WORDS));
    localparam logic UPD_Q = ((g % 2) == 1);
    localparam logic SKIP  = (g >= MAC_ROUNDS);

    gbc_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .round_key (key_r[KIDX]),
      .upd_q     (UPD_Q),
      .mac_skip  (SKIP),
      .stg_i     (stg[g]),
      .stg_o     (stg[g+1])
    );
  end

  // map p and q back to the a and b halves
  always_comb begin
    if (stg[NUM_ROUNDS].op == OP_ENCRYPT) begin
      out_data_nxt.half_a_out = stg[NUM_ROUNDS].p;
      out_data_nxt.half_b_out = stg[NUM_ROUNDS].q;
    end else begin
      out_data_nxt.half_a_out = stg[NUM_ROUNDS].q;
      out_data_nxt.half_b_out = stg[NUM_ROUNDS].p;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= stg[NUM_ROUNDS].valid;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // every accepted transaction comes out after the fixed latency
  `GBC_ASSERT_DELAY(a_result_follows, accept, LATENCY, out_strobe, "missing result strobe")
  // no result strobe without a transaction accepted the latency before
  `GBC_ASSERT_NOW(a_no_phantom, out_strobe, $past(accept, LATENCY), "result without transaction")
  // writes beyond the key words leave the key untouched
  `GBC_ASSERT_NEXT(a_cfg_ignore, cfg_stray, $stable(key_r), "unmapped write changed key")

endmodule

`default_nettype wire

### verif/gost_block_cipher_core_test.sv
// self-checking testbench for gost_block_cipher_core: keyed block transactions in,
// halves out; a scoreboard class predicts every result; depends on gbc_pkg and the core
`timescale 1ns / 100ps

module gost_block_cipher_core_test;
  import gbc_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 9;
  localparam int PIPE_DEPTH     = 34;    // input reg, 32 rounds, output reg
  localparam int IDLE_PERCENT   = 24;
  localparam int PHASE_ITEMS    = 104;
  localparam int WATCHDOG_LIMIT = 4000;
  // register index map: key words sit at 0..7, anything above is unmapped
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_FIRST   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 4'd15;

  // substitution table kept here on its own, independent of the design's rom
  localparam logic [31:0] SUBST_TABLE [16] = '{
    32'hc983edc4, 32'h6bfe9892, 32'h5c65beff, 32'h20b92ce5,
    32'hb3165789, 32'h0698f311, 32'h97c07930, 32'hd55d1aa8,
    32'h34da012e, 32'he83bd573, 32'h7e77c24b, 32'hafac64dc,
    32'hf102a66d, 32'h4ae14f07, 32'h122f30ba, 32'h8d448b56
  };

  typedef logic [31:0] key_set_t [KEY_WORDS];

  // scoreboard: mirrors the key registers and holds the expected halves in order
  class cipher_scoreboard;
    logic [31:0] key_word [KEY_WORDS];
    out_t        pending_blocks [$];
    int unsigned mismatches;

    function new();
      foreach (key_word[i]) key_word[i] = '0;
      mismatches = 0;
    endfunction

    // writes above the last key word are dropped by the block
    function void set_key(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
      if (idx < KEY_WORDS) key_word[idx[KEY_IDX_W-1:0]] = value;
    endfunction

    // one round: add key, substitute each nibble, rotate left 11, xor into x
    function logic [31:0] gost_round(logic [31:0] x, logic [31:0] y, logic [31:0] k);
      logic [31:0] sum;
      logic [31:0] sub;
      logic [31:0] row;
      sum = y + k;
      sub = '0;
      for (int n = 0; n < 8; n++) begin
        row = SUBST_TABLE[sum[4*n +: 4]];
        sub[4*n +: 4] = row[4*n +: 4];
      end
      return x ^ {sub[20:0], sub[31:21]};
    endfunction

    function out_t encipher(in_t blk);
      logic [31:0] a;
      logic [31:0] b;
      out_t res;
      if (blk.operation == OP_MAC) begin
        // mac step: no swap, key words 0..7 twice, b updated first
        a = blk.half_a_in;
        b = blk.half_b_in;
        for (int r = 0; r < 2; r++) begin
          for (int i = 0; i < KEY_WORDS; i += 2) begin
            b = gost_round(b, a, key_word[i]);
            a = gost_round(a, b, key_word[i + 1]);
          end
        end
      end else begin
        // encrypt: swap, key words 0..7 three times, then 7..0 once
        a = blk.half_b_in;
        b = blk.half_a_in;
        for (int r = 0; r < 3; r++) begin
          for (int i = 0; i < KEY_WORDS; i += 2) begin
            a = gost_round(a, b, key_word[i]);
            b = gost_round(b, a, key_word[i + 1]);
          end
        end
        for (int i = 0; i < KEY_WORDS; i += 2) begin
          a = gost_round(a, b, key_word[7 - i]);
          b = gost_round(b, a, key_word[6 - i]);
        end
      end
      res.half_a_out = a;
      res.half_b_out = b;
      return res;
    endfunction

    function void note_block(in_t blk);
      pending_blocks.push_back(encipher(blk));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_blocks.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual a=%h b=%h",
                 $time, got.half_a_out, got.half_b_out);
        mismatches++;
        return;
      end
      want = pending_blocks.pop_front();
      if (got.half_a_out !== want.half_a_out) begin
        $display("%0t: half_a_out mismatch, expected %h, actual %h",
                 $time, want.half_a_out, got.half_a_out);
        mismatches++;
      end
      if (got.half_b_out !== want.half_b_out) begin
        $display("%0t: half_b_out mismatch, expected %h, actual %h",
                 $time, want.half_b_out, got.half_b_out);
        mismatches++;
      end
    endfunction
  endclass

  // clock, reset and every block input start at known values
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_strobe;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  cipher_scoreboard sb = new();
  int unsigned quiet_cycles = 0;
  bit idling_on = 1'b1;

  gost_block_cipher_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // monitor: an input transaction is taken when start is high and busy low,
  // a result is valid only in its strobe cycle and must be taken right away
  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_block(in_data);
    if (rst_n && out_strobe) sb.check_result(out_data);
    if ((rst_n && start && !busy) || (rst_n && out_strobe)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog: too long without any transaction in either direction
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // offer one block and hold it until the block takes it; start stays high
  // afterwards so back-to-back transactions need no extra edge
  task automatic send_block(in_t blk);
    // each cycle idles on its own draw, so idle cycles make up IDLE_PERCENT
    while (idling_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      start <= 1'b0;
      in_data <= {1'($urandom), $urandom, $urandom};    // noise while nothing is offered
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= blk;
    do @(posedge clk); while (busy);
  endtask

  // stop offering and wait for every expected result to come back
  task automatic drain;
    start <= 1'b0;
    while (sb.pending_blocks.size() != 0) @(posedge clk);
  endtask

  // write all key words plus one unmapped index that must be ignored;
  // cfg_we is lowered once at the end so it never toggles within one step
  task automatic load_key(key_set_t words);
    logic [CFG_IDX_W-1:0] stray;
    logic [31:0] junk;
    stray = CFG_IDX_W'($urandom_range(CFG_UNMAPPED_LO, CFG_UNMAPPED_HI));
    junk = $urandom;
    cfg_we <= 1'b1;
    cfg_index <= stray;
    cfg_wdata <= junk;
    @(posedge clk);
    sb.set_key(stray, junk);
    for (int i = 0; i < KEY_WORDS; i++) begin
      cfg_index <= CFG_KEY_FIRST + CFG_IDX_W'(i);
      cfg_wdata <= words[i];
      @(posedge clk);
      sb.set_key(CFG_KEY_FIRST + CFG_IDX_W'(i), words[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // corner halves for both operations: all zero, all one, carries, patterns
  task automatic run_corners;
    logic [31:0] pat_a [7] = '{32'h0, 32'hffffffff, 32'h0, 32'hffffffff,
                               32'h80000000, 32'haaaaaaaa, 32'h01234567};
    logic [31:0] pat_b [7] = '{32'h0, 32'hffffffff, 32'hffffffff, 32'h0,
                               32'h00000001, 32'h55555555, 32'h89abcdef};
    in_t blk;
    for (int op = 0; op < 2; op++) begin
      for (int i = 0; i < 7; i++) begin
        blk.operation = (op == 0) ? OP_ENCRYPT : OP_MAC;
        blk.half_a_in = pat_a[i];
        blk.half_b_in = pat_b[i];
        send_block(blk);
      end
    end
  endtask

  function automatic logic [31:0] pick_half();
    logic [31:0] edges [4] = '{32'h0, 32'hffffffff, 32'h80000000, 32'h7fffffff};
    if ($urandom_range(0, 9) == 0) return edges[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  task automatic run_random(int unsigned count);
    in_t blk;
    repeat (count) begin
      blk.operation = $urandom_range(0, 1) ? OP_MAC : OP_ENCRYPT;
      blk.half_a_in = pick_half();
      blk.half_b_in = pick_half();
      send_block(blk);
    end
  endtask

  initial begin
    key_set_t key_pick;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset key (all zero) with the corner blocks
    run_corners();
    run_random(PHASE_ITEMS / 2);
    drain();

    // all-ones key: every key addition with a nonzero half wraps
    foreach (key_pick[i]) key_pick[i] = 32'hffffffff;
    load_key(key_pick);
    run_corners();
    run_random(PHASE_ITEMS);
    drain();

    // alternating zero / all-ones words, full-rate stretch with no gaps
    foreach (key_pick[i]) key_pick[i] = (i % 2) ? 32'hffffffff : 32'h0;
    load_key(key_pick);
    idling_on = 1'b0;
    run_random(PHASE_ITEMS);
    idling_on = 1'b1;
    drain();

    // random keys
    repeat (4) begin
      foreach (key_pick[i]) key_pick[i] = $urandom;
      load_key(key_pick);
      run_random(PHASE_ITEMS);
      drain();
    end

    // let anything stray fall out of the pipeline before judging
    repeat (PIPE_DEPTH + 6) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_blocks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/gbc_pkg.sv
hw/rtl/gbc_round.sv
hw/rtl/gost_block_cipher_core.sv
verif/gost_block_cipher_core_test.sv
